FILE: rtl/hpts_pkg.sv
// ----------------------------------------------------------------------------
// hpts_pkg: shared types and constants of the haptic pulse train sequencer
// Holds the beat payloads, the command and status codes, the controller
// states and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package hpts_pkg;

	// Default configuration of the top level.
	localparam int NOTE_DEPTH_DEF      = 64;
	localparam int DUTY_FULL_SCALE_DEF = 512;

	// Microsecond ticks in one second and in one millisecond.
	localparam int TICKS_PER_S = 1000000;
	localparam int US_PER_MS   = 1000;

	// Any 32-bit value divided by 1000 equals (value * REP_MUL) >> REP_SH.
	localparam longint unsigned REP_MUL   = 64'd274877907;
	localparam int              REP_MUL_W = 29;
	localparam int              REP_SH    = 38;

	// Fixed field widths of the timing values.
	localparam int PERIOD_W = 20;
	localparam int PHASE_W  = 26;
	localparam int REP_W    = 23;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_START = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} hpts_cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BUSY  = 2'd1,
		ST_ZERO  = 2'd2,
		ST_RANGE = 2'd3
	} hpts_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_TICK,
		S_LD_CHECK,
		S_LD_EVAL,
		S_P_START,
		S_P_WAIT,
		S_H_MUL,
		S_H_START,
		S_H_WAIT,
		S_R_MUL,
		S_R_START,
		S_R_WAIT,
		S_DONE
	} hpts_state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        channel;
		logic [5:0]  note_index;
		logic [15:0] duty;
		logic [15:0] freq_hz;
		logic [15:0] duration_ms;
		logic [6:0]  note_count;
	} hpts_in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       right_level;
		logic       left_level;
		logic       right_busy;
		logic       left_busy;
	} hpts_out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic         in_ready;
		logic         chan;
		logic         mem_wr;
		logic         set_err;
		logic         start_init;
		logic         tick_step;
		logic         rd;
		logic         skip;
		logic         go_idle;
		logic         load_delay;
		logic         latch_note;
		logic         div_start;
		logic         store_period;
		logic         mul_high;
		logic         scale_high;
		logic         store_high;
		logic         mul_rep;
		logic         scale_rep;
		logic         commit;
		logic         out_load;
	} hpts_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic           in_valid;
		hpts_cmd_code_t cmd;
		logic           chan;
		hpts_status_t   err;
		logic           need_load;
		logic           cur_lt_end;
		logic           dur_zero;
		logic           delay_note;
		logic           div_busy;
		logic           div_done;
		logic           out_free;
	} hpts_sts_t;

endpackage

`default_nettype wire

FILE: rtl/hpts_if.sv
// ----------------------------------------------------------------------------
// hpts_in_if / hpts_out_if: valid/ready channels of the sequencer
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpts_in_if;
	logic                   valid;
	logic                   ready;
	hpts_pkg::hpts_in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hpts_out_if;
	logic                    valid;
	logic                    ready;
	hpts_pkg::hpts_out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/hpts_ram.sv
// ----------------------------------------------------------------------------
// hpts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hpts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/hpts_div.sv
// ----------------------------------------------------------------------------
// hpts_div: restoring divider, one quotient bit per cycle
// Done pulses for one cycle at the end of the division.
// ----------------------------------------------------------------------------
`default_nettype none

module hpts_div #(
	parameter int DVD_W = 32,
	parameter int DVS_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic      [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             qbit;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

FILE: rtl/hpts_ctrl.sv
// ----------------------------------------------------------------------------
// hpts_ctrl: sequencing controller of the pulse train sequencer
// Steps one command through decode, channel ticks, note loading, the period
// division and the scaling steps, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpts_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hpts_pkg::hpts_sts_t sts,
	output hpts_pkg::hpts_cmd_t      cmd
);

	hpts_pkg::hpts_state_t state_q, state_d;
	logic                  chan_q, chan_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hpts_pkg::S_IDLE;
			chan_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			chan_q  <= chan_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		hpts_pkg::hpts_state_t after_load;

		cmd     = '0;
		cmd.chan = chan_q;
		state_d = state_q;
		chan_d  = chan_q;

		// A tick goes on to the left channel once the right one is done.
		if (sts.cmd == hpts_pkg::CMD_TICK && !chan_q) begin
			after_load = hpts_pkg::S_TICK;
		end else begin
			after_load = hpts_pkg::S_DONE;
		end

		case (state_q)
			hpts_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					state_d = hpts_pkg::S_DECODE;
				end
			end
			hpts_pkg::S_DECODE: begin
				case (sts.cmd)
					hpts_pkg::CMD_WRITE: begin
						cmd.mem_wr = 1'b1;
						state_d    = hpts_pkg::S_DONE;
					end
					hpts_pkg::CMD_START: begin
						cmd.chan = sts.chan;
						chan_d   = sts.chan;
						if (sts.err != hpts_pkg::ST_OK) begin
							cmd.set_err = 1'b1;
							state_d     = hpts_pkg::S_DONE;
						end else begin
							cmd.start_init = 1'b1;
							state_d        = hpts_pkg::S_LD_CHECK;
						end
					end
					hpts_pkg::CMD_TICK: begin
						chan_d  = 1'b0;
						state_d = hpts_pkg::S_TICK;
					end
					default: begin
						state_d = hpts_pkg::S_DONE;
					end
				endcase
			end
			hpts_pkg::S_TICK: begin
				cmd.tick_step = 1'b1;
				if (sts.need_load) begin
					state_d = hpts_pkg::S_LD_CHECK;
				end else if (!chan_q) begin
					chan_d = 1'b1;
				end else begin
					state_d = hpts_pkg::S_DONE;
				end
			end
			hpts_pkg::S_LD_CHECK: begin
				if (sts.cur_lt_end) begin
					cmd.rd  = 1'b1;
					state_d = hpts_pkg::S_LD_EVAL;
				end else begin
					cmd.go_idle = 1'b1;
					if (after_load == hpts_pkg::S_TICK) begin
						chan_d = 1'b1;
					end
					state_d = after_load;
				end
			end
			hpts_pkg::S_LD_EVAL: begin
				if (sts.dur_zero) begin
					cmd.skip = 1'b1;
					state_d  = hpts_pkg::S_LD_CHECK;
				end else if (sts.delay_note) begin
					cmd.load_delay = 1'b1;
					if (after_load == hpts_pkg::S_TICK) begin
						chan_d = 1'b1;
					end
					state_d = after_load;
				end else begin
					cmd.latch_note = 1'b1;
					state_d        = hpts_pkg::S_P_START;
				end
			end
			hpts_pkg::S_P_START: begin
				cmd.div_start = 1'b1;
				state_d       = hpts_pkg::S_P_WAIT;
			end
			hpts_pkg::S_P_WAIT: begin
				if (sts.div_done) begin
					cmd.store_period = 1'b1;
					state_d          = hpts_pkg::S_H_MUL;
				end
			end
			hpts_pkg::S_H_MUL: begin
				cmd.mul_high = 1'b1;
				state_d      = hpts_pkg::S_H_START;
			end
			hpts_pkg::S_H_START: begin
				cmd.scale_high = 1'b1;
				state_d        = hpts_pkg::S_H_WAIT;
			end
			hpts_pkg::S_H_WAIT: begin
				cmd.store_high = 1'b1;
				state_d        = hpts_pkg::S_R_MUL;
			end
			hpts_pkg::S_R_MUL: begin
				cmd.mul_rep = 1'b1;
				state_d     = hpts_pkg::S_R_START;
			end
			hpts_pkg::S_R_START: begin
				cmd.scale_rep = 1'b1;
				state_d       = hpts_pkg::S_R_WAIT;
			end
			hpts_pkg::S_R_WAIT: begin
				cmd.commit = 1'b1;
				if (after_load == hpts_pkg::S_TICK) begin
					chan_d = 1'b1;
				end
				state_d = after_load;
			end
			hpts_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = hpts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = hpts_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/hpts_dp.sv
// ----------------------------------------------------------------------------
// hpts_dp: datapath of the pulse train sequencer
// Holds the item register, note memory, per-channel phase state, the
// multiplier, divider and scaling work registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpts_dp #(
	parameter int NOTE_DEPTH      = hpts_pkg::NOTE_DEPTH_DEF,
	parameter int DUTY_FULL_SCALE = hpts_pkg::DUTY_FULL_SCALE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hpts_pkg::hpts_cmd_t cmd,
	output hpts_pkg::hpts_sts_t      sts,
	hpts_in_if.sink                  req,
	hpts_out_if.source               rsp
);

	localparam int AW     = $clog2(NOTE_DEPTH);
	localparam int NW     = $clog2(NOTE_DEPTH + 1);
	localparam int XW     = (AW > 6) ? AW : 6;
	localparam int CKW    = (NW > 8) ? NW : 8;
	localparam int DUTY_W = $clog2(DUTY_FULL_SCALE + 1);
	localparam int DVD_W  = (hpts_pkg::PERIOD_W + DUTY_W > 32) ?
		hpts_pkg::PERIOD_W + DUTY_W : 32;
	localparam int PW     = hpts_pkg::PERIOD_W;
	localparam int PHW    = hpts_pkg::PHASE_W;
	localparam int RW     = hpts_pkg::REP_W;

	// Division of period*duty by the full scale: a shift for a power of two,
	// otherwise a multiplication by the rounded-up reciprocal and a shift.
	localparam int HN  = PW + DUTY_W;
	localparam int HL  = $clog2(DUTY_FULL_SCALE);
	localparam bit HP2 = ((1 << HL) == DUTY_FULL_SCALE);
	localparam int HK  = HN + HL;
	localparam longint unsigned HM = HP2 ? 64'd1 :
		(((64'd1 << HK) + 64'(DUTY_FULL_SCALE) - 64'd1) / 64'(DUTY_FULL_SCALE));
	localparam int HS  = HP2 ? HL : HK;
	localparam int HPW = 2 * HN + 1;
	localparam int RPW = 32 + hpts_pkg::REP_MUL_W;

	hpts_pkg::hpts_in_item_t item_q;
	hpts_pkg::hpts_status_t  status_q;

	logic [1:0]     busy_q;
	logic [1:0]     level_q;
	logic [PHW-1:0] phase_q [2];
	logic [PW-1:0]  high_q  [2];
	logic [PHW-1:0] low_q   [2];
	logic [RW-1:0]  rep_q   [2];
	logic [NW-1:0]  cur_q   [2];
	logic [NW-1:0]  end_q   [2];

	logic [DUTY_W-1:0] duty_q;
	logic [15:0]       freq_q;
	logic [15:0]       dur_q;
	logic [PW-1:0]     period_q;
	logic [PW-1:0]     hi_q;
	logic [DVD_W-1:0]  prod_q;
	logic [HPW-1:0]    hscale_q;
	logic [RPW-1:0]    rscale_q;

	logic              out_valid_q;
	hpts_pkg::hpts_out_item_t out_q;

	logic              c;
	logic [XW-1:0]     idx_x;
	logic [CKW-1:0]    run_end;
	logic              wr_ok;
	logic [47:0]       rdata;
	logic [15:0]       rd_duty;
	logic [15:0]       rd_freq;
	logic [15:0]       rd_dur;
	logic [16:0]       duty_x;
	logic [DUTY_W-1:0] duty_sat;
	logic [RW-1:0]     rep_dec;
	logic [RW-1:0]     rep_raw;
	logic [PW-1:0]     quot;
	logic              div_busy;
	logic              div_done;
	logic [RW-1:0]     rep_new;
	logic              accept;

	assign c      = cmd.chan;
	assign accept = cmd.in_ready && req.valid;

	// Address and run checks on the held item.
	always_comb begin
		idx_x   = XW'(item_q.note_index);
		run_end = CKW'(item_q.note_index) + CKW'(item_q.note_count);
		wr_ok   = ({1'b0, idx_x} < (XW + 1)'(NOTE_DEPTH));
	end

	// Note fields from the memory, with duty saturation.
	always_comb begin
		rd_duty = rdata[47:32];
		rd_freq = rdata[31:16];
		rd_dur  = rdata[15:0];
		duty_x  = {1'b0, rd_duty};
		if (duty_x > 17'(DUTY_FULL_SCALE)) begin
			duty_sat = DUTY_W'(DUTY_FULL_SCALE);
		end else begin
			duty_sat = DUTY_W'(duty_x);
		end
	end

	// Repeat counter step of the selected channel, and the new repeat count.
	assign rep_dec = (rep_q[c] != '0) ? rep_q[c] - 1'b1 : '0;
	assign rep_raw = RW'(rscale_q >> hpts_pkg::REP_SH);
	assign rep_new = (rep_raw != '0) ? rep_raw : RW'(1);

	hpts_ram #(
		.WIDTH(48),
		.DEPTH(NOTE_DEPTH)
	) u_note_ram (
		.clk  (clk),
		.we   (cmd.mem_wr && wr_ok),
		.waddr(idx_x[AW-1:0]),
		.wdata({item_q.duty, item_q.freq_hz, item_q.duration_ms}),
		.re   (cmd.rd),
		.raddr(cur_q[c][AW-1:0]),
		.rdata(rdata)
	);

	// The period division is the only one by a variable.
	hpts_div #(
		.DVD_W(PW),
		.DVS_W(16)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(PW'(hpts_pkg::TICKS_PER_S)),
		.divisor (freq_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(quot)
	);

	// Status towards the controller.
	always_comb begin
		sts            = '0;
		sts.in_valid   = req.valid;
		sts.cmd        = hpts_pkg::hpts_cmd_code_t'(item_q.cmd);
		sts.chan       = item_q.channel;
		if (busy_q[item_q.channel]) begin
			sts.err = hpts_pkg::ST_BUSY;
		end else if (item_q.note_count == '0) begin
			sts.err = hpts_pkg::ST_ZERO;
		end else if (run_end > CKW'(NOTE_DEPTH)) begin
			sts.err = hpts_pkg::ST_RANGE;
		end else begin
			sts.err = hpts_pkg::ST_OK;
		end
		sts.need_load  = busy_q[c] && (phase_q[c] <= PHW'(1)) && !level_q[c] &&
			(rep_dec == '0);
		sts.cur_lt_end = (cur_q[c] < end_q[c]);
		sts.dur_zero   = (rd_dur == '0);
		sts.delay_note = (rd_duty == '0) || (rd_freq == '0);
		sts.div_busy   = div_busy;
		sts.div_done   = div_done;
		sts.out_free   = !out_valid_q || rsp.ready;
	end

	// Item register and per-command status.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= req.data;
			status_q <= hpts_pkg::ST_OK;
		end else if (cmd.set_err) begin
			status_q <= sts.err;
		end
	end

	// Channel control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			level_q <= '0;
			for (int i = 0; i < 2; i++) begin
				phase_q[i] <= '0;
				high_q[i]  <= '0;
				low_q[i]   <= '0;
				rep_q[i]   <= '0;
				cur_q[i]   <= '0;
				end_q[i]   <= '0;
			end
		end else begin
			if (cmd.start_init) begin
				cur_q[c] <= NW'(item_q.note_index);
				end_q[c] <= run_end[NW-1:0];
			end
			if (cmd.tick_step && busy_q[c]) begin
				if (phase_q[c] > PHW'(1)) begin
					phase_q[c] <= phase_q[c] - 1'b1;
				end else if (level_q[c]) begin
					level_q[c] <= 1'b0;
					phase_q[c] <= low_q[c];
				end else begin
					rep_q[c] <= rep_dec;
					if (rep_dec != '0) begin
						level_q[c] <= 1'b1;
						phase_q[c] <= PHW'(high_q[c]);
					end else begin
						cur_q[c] <= cur_q[c] + 1'b1;
					end
				end
			end
			if (cmd.skip) begin
				cur_q[c] <= cur_q[c] + 1'b1;
			end
			if (cmd.go_idle) begin
				busy_q[c]  <= 1'b0;
				level_q[c] <= 1'b0;
				phase_q[c] <= '0;
			end
			if (cmd.load_delay) begin
				busy_q[c]  <= 1'b1;
				level_q[c] <= 1'b0;
				high_q[c]  <= '0;
				low_q[c]   <= PHW'(rd_dur) * PHW'(hpts_pkg::US_PER_MS);
				phase_q[c] <= PHW'(rd_dur) * PHW'(hpts_pkg::US_PER_MS);
				rep_q[c]   <= RW'(1);
			end
			if (cmd.commit) begin
				busy_q[c]  <= 1'b1;
				level_q[c] <= 1'b1;
				high_q[c]  <= hi_q;
				low_q[c]   <= PHW'(period_q - hi_q);
				phase_q[c] <= PHW'(hi_q);
				rep_q[c]   <= rep_new;
			end
		end
	end

	// Note arithmetic work registers.
	always_ff @(posedge clk) begin
		if (cmd.latch_note) begin
			duty_q <= duty_sat;
			freq_q <= rd_freq;
			dur_q  <= rd_dur;
		end
		if (cmd.store_period) begin
			period_q <= quot;
		end
		if (cmd.mul_high) begin
			prod_q <= DVD_W'(period_q) * DVD_W'(duty_q);
		end else if (cmd.mul_rep) begin
			prod_q <= DVD_W'(dur_q) * DVD_W'(freq_q);
		end
		// Constant divisions by reciprocal multiplication.
		if (cmd.scale_high) begin
			hscale_q <= HPW'(prod_q[HN-1:0]) * HPW'(HM);
		end
		if (cmd.store_high) begin
			hi_q <= PW'(hscale_q >> HS);
		end
		if (cmd.scale_rep) begin
			rscale_q <= RPW'(prod_q[31:0]) * RPW'(hpts_pkg::REP_MUL);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status      <= status_q;
			out_q.right_level <= level_q[0];
			out_q.left_level  <= level_q[1];
			out_q.right_busy  <= busy_q[0];
			out_q.left_busy   <= busy_q[1];
		end
	end

	assign req.ready = cmd.in_ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

`default_nettype wire

FILE: rtl/haptic_pulse_train_sequencer_unit.sv
// Flow: a write, an unused command or a refused start goes from decode to the done state;
// a tick steps the right channel, then the left. Each note load checks and reads a note;
// a pulse note runs the period division, one quotient bit per cycle while busy, and the
// scaling steps. The done state then waits for a free output register.
// Throughput: one item at a time; the next item is taken once its result sits in the
// output register. Reset idles both channels; note memory is undefined until written.
// ----------------------------------------------------------------------------
// haptic_pulse_train_sequencer_unit: two-channel haptic pulse sequencer
// Plays runs of notes from a shared note memory on two drive outputs,
// stepped by one-microsecond tick commands.
// ----------------------------------------------------------------------------
`default_nettype none

module haptic_pulse_train_sequencer_unit #(
	parameter int NOTE_DEPTH      = hpts_pkg::NOTE_DEPTH_DEF,
	parameter int DUTY_FULL_SCALE = hpts_pkg::DUTY_FULL_SCALE_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	hpts_in_if.sink    req,
	hpts_out_if.source rsp
);

	hpts_pkg::hpts_cmd_t cmd;
	hpts_pkg::hpts_sts_t sts;

	hpts_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	hpts_dp #(
		.NOTE_DEPTH     (NOTE_DEPTH),
		.DUTY_FULL_SCALE(DUTY_FULL_SCALE)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.req   (req),
		.rsp   (rsp)
	);

	// An accepted beat is worked on alone.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("input taken while an item is in work");

	// The divider is never restarted mid-division.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	// A result is only loaded into a free output register.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result overwrote an untaken beat");

	// A result beat only leaves once it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp.valid) |-> $past(rsp.ready))
		else $error("result beat dropped");

endmodule

`default_nettype wire
